FILE: design/brbf_pkg.sv
// ============================================================================
// brbf_pkg: shared types and constants of the bus ROM bank flipper
// Holds the address geometry, the marker addresses, the action and operation
// codes and the item record that travels from the front end to the back end.
// ============================================================================
package brbf_pkg;

    // Address geometry of one sub-bank and of the whole bank memory.
    localparam int ADDR_BITS     = 14;
    localparam int MEM_ADDR_BITS = ADDR_BITS + 2;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

    // Number of keyboard rows captured after the capture marker.
    localparam int KEY_ROWS  = 8;
    localparam int KEY_CNT_W = 4;
    localparam logic [KEY_CNT_W-1:0] KEY_CNT_INIT = KEY_CNT_W'(KEY_ROWS);

    // Widths of the fixed interface fields.
    localparam int BUS_ADDR_W = 14;
    localparam int DELAY_W    = 4;

    // Bus address mask, marker addresses and the high byte of the row window.
    localparam logic [15:0] ADDR_MASK     = 16'((32'd1 << ADDR_BITS) - 32'd1);
    localparam logic [15:0] ADDR_KEY_MARK = 16'h3fff;
    localparam logic [15:0] ADDR_HALT_MARK = 16'h3ffe;
    localparam logic [15:0] ADDR_SWAP_MARK = 16'h3ffd;
    localparam logic [15:0] KEY_ROW_HIGH  = 16'h003f;

    // Reset values of the delay registers.
    localparam logic [DELAY_W-1:0] HALT_DELAY_RST = 4'd2;
    localparam logic [DELAY_W-1:0] SWAP_DELAY_RST = 4'd3;

    // Configuration register indexes.
    localparam logic CFG_HALT_DELAY = 1'b0;
    localparam logic CFG_SWAP_DELAY = 1'b1;

    // Action codes on the input channel.
    localparam logic [1:0] ACT_READ = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_FLIP = 2'd2;

    // Operation after classification.
    typedef enum logic [1:0] {
        OP_READ,
        OP_LOAD,
        OP_FLIP,
        OP_NONE
    } t_op;

    // One classified item, as it waits in the queue.
    typedef struct packed {
        t_op                  op;
        logic [ADDR_BITS-1:0] addr;
        logic                 load_sub_bank;
        logic [7:0]           load_data;
        logic                 is_key_mark;
        logic                 is_key_row;
        logic                 is_halt_mark;
        logic                 is_swap_mark;
    } t_item;

    // Fill status of the queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

FILE: design/brbf_front.sv
// ============================================================================
// brbf_front: input transfer and classification
// Takes input transfers while the queue has room, decodes the action and
// flags the marker addresses so that the back end sees ready-made decisions.
// ============================================================================
module brbf_front (
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_action,
    input  logic [brbf_pkg::BUS_ADDR_W-1:0] i_bus_address,
    input  logic                           i_load_sub_bank,
    input  logic [7:0]                     i_load_data,
    input  brbf_pkg::t_queue_status        i_status,
    output logic                           o_push,
    output brbf_pkg::t_item                o_item
);
    import brbf_pkg::*;

    logic [15:0] addr_ext;

    // The queue applies back pressure only when it is full.
    assign o_in_stall = i_status.full;
    assign o_push     = i_in_valid & ~i_status.full;

    // The bus address is cut down to the sub-bank address space.
    assign addr_ext = 16'(i_bus_address) & ADDR_MASK;

    // Decode the action and flag the marker addresses.
    always_comb begin
        case (i_action)
            ACT_READ: o_item.op = OP_READ;
            ACT_LOAD: o_item.op = OP_LOAD;
            ACT_FLIP: o_item.op = OP_FLIP;
            default:  o_item.op = OP_NONE;
        endcase
        o_item.addr          = addr_ext[ADDR_BITS-1:0];
        o_item.load_sub_bank = i_load_sub_bank;
        o_item.load_data     = i_load_data;
        o_item.is_key_mark   = (addr_ext == ADDR_KEY_MARK);
        o_item.is_key_row    = ((addr_ext >> 8) == KEY_ROW_HIGH);
        o_item.is_halt_mark  = (addr_ext == ADDR_HALT_MARK);
        o_item.is_swap_mark  = (addr_ext == ADDR_SWAP_MARK);
    end

endmodule

FILE: design/brbf_queue.sv
// ============================================================================
// brbf_queue: two-entry queue between front and back end
// Decouples the input side from the back end so that each can stall on its
// own while the other keeps moving.
// ============================================================================
module brbf_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  brbf_pkg::t_item         i_item,
    input  logic                    i_pop,
    output brbf_pkg::t_item         o_head,
    output brbf_pkg::t_queue_status o_status
);
    import brbf_pkg::*;

    t_item      r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_head          = r_entry[r_rd_ptr];
    assign o_status.empty  = (r_count == 2'd0);
    assign o_status.full   = (r_count == 2'd2);

    // Fill count follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: design/brbf_back.sv
// ============================================================================
// brbf_back: bank memory, marker sequencing and result output
// Executes one queued item per cycle unless the output stalls: updates the
// bank and countdown state, issues the memory access, and moves the result
// through a data stage into the output register.
module brbf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [brbf_pkg::DELAY_W-1:0] i_cfg_data,
    input  brbf_pkg::t_item             i_head,
    input  brbf_pkg::t_queue_status     i_status,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [7:0]                  o_read_data,
    output logic                        o_key_valid,
    output logic [2:0]                  o_key_row,
    output logic [4:0]                  o_key_bits,
    output logic                        o_frame_done,
    output logic                        o_current_write_bank
);
    import brbf_pkg::*;

    // Configuration registers.
    logic [DELAY_W-1:0]   r_halt_delay;
    logic [DELAY_W-1:0]   r_swap_delay;

    // Bank and countdown state.
    logic                 r_read_bank,   n_read_bank;
    logic                 r_write_bank,  n_write_bank;
    logic                 r_read_sub,    n_read_sub;
    logic                 r_flip_pending, n_flip_pending;
    logic [KEY_CNT_W-1:0] r_key_count,   n_key_count;
    logic [DELAY_W-1:0]   r_halt_count,  n_halt_count;
    logic [DELAY_W-1:0]   r_swap_count,  n_swap_count;

    // Memory.
    logic [7:0]               r_mem [MEM_DEPTH];
    logic [7:0]               r_mem_q;
    logic                     mem_we;
    logic                     mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_waddr;
    logic [MEM_ADDR_BITS-1:0] mem_raddr;

    // Side results of the execute step.
    logic       n_kvalid;
    logic [2:0] n_krow;
    logic [4:0] n_kbits;
    logic       n_fdone;

    // Data stage.
    logic       r_b_valid;
    logic       r_b_is_read;
    logic       r_b_kvalid;
    logic [2:0] r_b_krow;
    logic [4:0] r_b_kbits;
    logic       r_b_fdone;
    logic       r_b_wbank;

    // Handshake between the stages.
    logic out_move;
    logic b_free;
    logic a_fire;

    assign out_move = ~o_out_valid | ~i_out_stall;
    assign b_free   = ~r_b_valid | out_move;
    assign a_fire   = ~i_status.empty & b_free;
    assign o_pop    = a_fire;

    assign mem_waddr = {r_write_bank, i_head.load_sub_bank, i_head.addr};
    assign mem_raddr = {r_read_bank, r_read_sub, i_head.addr};

    // Execute step: state update in the fixed marker priority order.
    always_comb begin
        n_read_bank    = r_read_bank;
        n_write_bank   = r_write_bank;
        n_read_sub     = r_read_sub;
        n_flip_pending = r_flip_pending;
        n_key_count    = r_key_count;
        n_halt_count   = r_halt_count;
        n_swap_count   = r_swap_count;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        n_kvalid       = 1'b0;
        n_krow         = 3'd0;
        n_kbits        = 5'd0;
        n_fdone        = 1'b0;
        if (a_fire) begin
            case (i_head.op)
                OP_LOAD: begin
                    mem_we = 1'b1;
                end
                OP_FLIP: begin
                    n_flip_pending = 1'b1;
                end
                OP_READ: begin
                    mem_re = 1'b1;
                    if (i_head.is_key_mark && r_key_count == '0) begin
                        n_key_count = KEY_CNT_INIT;
                    end else if (r_key_count != '0) begin
                        if (i_head.is_key_row) begin
                            n_key_count = r_key_count - 1'b1;
                            n_kvalid    = 1'b1;
                            n_krow      = 3'(r_key_count - 1'b1);
                            n_kbits     = ~i_head.addr[4:0];
                        end
                    end else if (i_head.is_halt_mark) begin
                        n_halt_count = r_halt_delay;
                    end else if (r_halt_count != '0) begin
                        n_halt_count = r_halt_count - 1'b1;
                        if (r_halt_count == DELAY_W'(1)) begin
                            n_read_sub = 1'b0;
                            if (r_flip_pending) begin
                                n_read_bank  = ~r_read_bank;
                                n_write_bank = ~r_write_bank;
                            end
                            n_flip_pending = 1'b0;
                            n_fdone        = 1'b1;
                        end
                    end else if (i_head.is_swap_mark) begin
                        n_swap_count = r_swap_delay;
                    end else if (r_swap_count != '0) begin
                        n_swap_count = r_swap_count - 1'b1;
                        if (r_swap_count == DELAY_W'(1)) begin
                            n_read_sub = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt_delay <= HALT_DELAY_RST;
            r_swap_delay <= SWAP_DELAY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALT_DELAY: r_halt_delay <= i_cfg_data;
                CFG_SWAP_DELAY: r_swap_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Bank and countdown state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_bank    <= 1'b0;
            r_write_bank   <= 1'b1;
            r_read_sub     <= 1'b0;
            r_flip_pending <= 1'b0;
            r_key_count    <= '0;
            r_halt_count   <= '0;
            r_swap_count   <= '0;
        end else begin
            r_read_bank    <= n_read_bank;
            r_write_bank   <= n_write_bank;
            r_read_sub     <= n_read_sub;
            r_flip_pending <= n_flip_pending;
            r_key_count    <= n_key_count;
            r_halt_count   <= n_halt_count;
            r_swap_count   <= n_swap_count;
        end
    end

    // Bank memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_head.load_data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // Data stage: side results wait here for the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire) begin
            r_b_valid <= 1'b1;
        end else if (out_move) begin
            r_b_valid <= 1'b0;
        end
        if (a_fire) begin
            r_b_is_read <= (i_head.op == OP_READ);
            r_b_kvalid  <= n_kvalid;
            r_b_krow    <= n_krow;
            r_b_kbits   <= n_kbits;
            r_b_fdone   <= n_fdone;
            r_b_wbank   <= n_write_bank;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_move) begin
            o_out_valid <= r_b_valid;
        end
        if (out_move && r_b_valid) begin
            o_read_data          <= r_b_is_read ? r_mem_q : 8'd0;
            o_key_valid          <= r_b_kvalid;
            o_key_row            <= r_b_krow;
            o_key_bits           <= r_b_kbits;
            o_frame_done         <= r_b_fdone;
            o_current_write_bank <= r_b_wbank;
        end
    end

    // The read bank and the write bank always differ.
    a_banks_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_bank != r_write_bank)
        else $error("read bank and write bank coincide");

    // A frame end with a pending flip swaps the read bank.
    a_flip_swaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_fdone && r_flip_pending) |=> (r_read_bank != $past(r_read_bank)))
        else $error("pending flip not carried out at frame end");

    // A row capture and a frame end never come from the same read.
    a_key_frame_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> !(r_b_kvalid && r_b_fdone))
        else $error("row capture and frame end on one read");

    // The capture counter never exceeds the row count.
    a_key_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KEY_CNT_INIT)
        else $error("keyboard capture counter out of range");

endmodule

FILE: design/bus_rom_bank_flipper.sv
// An item passes through a queue entry, the data stage and the output register.
// Throughput: one item per cycle while the output is not stalled; the back
// end executes one queued item each cycle via a registered-read bank memory.
// Reset: control state, countdowns and delay registers return to their reset
// values on a clock edge; bank memory contents are undefined until loaded.
// ============================================================================
// bus_rom_bank_flipper: double-buffered ROM emulation with marker addresses
// A front end classifies input transfers, a two-entry queue holds them, and
// the back end reads or loads the bank memory and runs the marker countdowns.
// ============================================================================
module bus_rom_bank_flipper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [brbf_pkg::DELAY_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_action,
    input  logic [brbf_pkg::BUS_ADDR_W-1:0] i_bus_address,
    input  logic                            i_load_sub_bank,
    input  logic [7:0]                      i_load_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_read_data,
    output logic                            o_key_valid,
    output logic [2:0]                      o_key_row,
    output logic [4:0]                      o_key_bits,
    output logic                            o_frame_done,
    output logic                            o_current_write_bank
);
    import brbf_pkg::*;

    t_item         front_item;
    t_item         queue_head;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    // Front end: input transfer and classification.
    brbf_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_bus_address   (i_bus_address),
        .i_load_sub_bank (i_load_sub_bank),
        .i_load_data     (i_load_data),
        .i_status        (queue_status),
        .o_push          (push),
        .o_item          (front_item)
    );

    // Queue between front and back end.
    brbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_head   (queue_head),
        .o_status (queue_status)
    );

    // Back end: memory, marker sequencing and output.
    brbf_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_head               (queue_head),
        .i_status             (queue_status),
        .o_pop                (pop),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_read_data          (o_read_data),
        .o_key_valid          (o_key_valid),
        .o_key_row            (o_key_row),
        .o_key_bits           (o_key_bits),
        .o_frame_done         (o_frame_done),
        .o_current_write_bank (o_current_write_bank)
    );

endmodule
